/* hdl/dfi_pkg.sv */
package dfi_pkg;

    // Reach of the fixed-width item fields
    localparam int MAX_TREES    = 8;    // tree_id is 3 bits
    localparam int MAX_NODES    = 256;  // node_addr and child slots are 8 bits
    localparam int MAX_FEATURES = 32;   // feature indexes are 5 bits
    localparam int MAX_CLASSES  = 16;   // labels are 4 bits

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [1:0] CMD_NODE     = 2'd0;
    localparam logic [1:0] CMD_FEAT     = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    typedef struct packed {
        logic               leaf;
        logic [4:0]         feature;
        logic signed [31:0] cutoff;
        logic [7:0]         left;
        logic [7:0]         right;
        logic [3:0]         label;
    } node_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [2:0]         tree_id;
        logic [7:0]         node_addr;
        node_t              node;
        logic [4:0]         feature_index;
        logic signed [31:0] feature_value;
    } dfi_op_t;

endpackage

/* hdl/decision_forest_inference_unit.sv */
// Decision forest classifier. Each transaction on start/busy is a node write, a feature
// write or a classify; writes and classifies pass through a four-entry command queue and
// run strictly in order, so busy rises only when that queue is full. A write is carried out
// by the execution engine as it is popped from the queue. A classify walks each tree in turn:
// each node visited costs a registered node-table read plus a registered feature read at
// inner nodes, and then the vote store is scanned one label per cycle.
// The result appears on the output ports for one
// cycle with done high and must be captured then; the receiver cannot stall it.
module decision_forest_inference_unit #(
    parameter int TREES          = 8,
    parameter int NODES_PER_TREE = 256,
    parameter int FEATURES       = 32,
    parameter int CLASSES        = 16,
    parameter int WALK_LIMIT     = 21
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [2:0]         tree_id,
    input  logic [7:0]         node_addr,
    input  logic               node_is_leaf,
    input  logic [4:0]         node_feature,
    input  logic signed [31:0] node_cutoff,
    input  logic [7:0]         node_left,
    input  logic [7:0]         node_right,
    input  logic [3:0]         node_label,
    input  logic [4:0]         feature_index,
    input  logic signed [31:0] feature_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data,
    output logic               done,
    output logic [3:0]         predicted_label,
    output logic [3:0]         winning_votes,
    output logic               walk_error
);

    import dfi_pkg::*;

    logic [3:0] trees_in_use_reg;
    logic       push;
    dfi_op_t    push_data;
    logic       full;
    logic       pop;
    dfi_op_t    head;
    logic       empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trees_in_use_reg <= 4'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            trees_in_use_reg <= cfg_data;
        end
    end

    dfi_front #(
        .TREES          (TREES),
        .NODES_PER_TREE (NODES_PER_TREE),
        .FEATURES       (FEATURES)
    ) u_front (
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .tree_id       (tree_id),
        .node_addr     (node_addr),
        .node_is_leaf  (node_is_leaf),
        .node_feature  (node_feature),
        .node_cutoff   (node_cutoff),
        .node_left     (node_left),
        .node_right    (node_right),
        .node_label    (node_label),
        .feature_index (feature_index),
        .feature_value (feature_value),
        .full          (full),
        .push          (push),
        .push_data     (push_data)
    );

    dfi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    dfi_back #(
        .TREES          (TREES),
        .NODES_PER_TREE (NODES_PER_TREE),
        .FEATURES       (FEATURES),
        .CLASSES        (CLASSES),
        .WALK_LIMIT     (WALK_LIMIT)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .trees_in_use    (trees_in_use_reg),
        .q_valid         (!empty),
        .q_head          (head),
        .q_pop           (pop),
        .done            (done),
        .predicted_label (predicted_label),
        .winning_votes   (winning_votes),
        .walk_error      (walk_error)
    );

endmodule

/* hdl/dfi_ram.sv */
module dfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/dfi_queue.sv */
module dfi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dfi_pkg::dfi_op_t  push_data,
    output logic              full,
    input  logic              pop,
    output dfi_pkg::dfi_op_t  head,
    output logic              empty
);

    import dfi_pkg::*;

    dfi_op_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue pop while empty");

endmodule

/* hdl/dfi_front.sv */
module dfi_front #(
    parameter int TREES          = 8,
    parameter int NODES_PER_TREE = 256,
    parameter int FEATURES       = 32
) (
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         cmd,
    input  logic [2:0]         tree_id,
    input  logic [7:0]         node_addr,
    input  logic               node_is_leaf,
    input  logic [4:0]         node_feature,
    input  logic signed [31:0] node_cutoff,
    input  logic [7:0]         node_left,
    input  logic [7:0]         node_right,
    input  logic [3:0]         node_label,
    input  logic [4:0]         feature_index,
    input  logic signed [31:0] feature_value,
    input  logic               full,
    output logic               push,
    output dfi_pkg::dfi_op_t   push_data
);

    import dfi_pkg::*;

    logic legal;

    // Drop writes that fall outside the tables and the unused command
    always_comb
    begin
        unique case (cmd)
            CMD_NODE:     legal = (32'(tree_id) < TREES) && (32'(node_addr) < NODES_PER_TREE);
            CMD_FEAT:     legal = (32'(feature_index) < FEATURES);
            CMD_CLASSIFY: legal = 1'b1;
            default:      legal = 1'b0;
        endcase
    end

    assign busy = full;
    assign push = start && !full && legal;

    always_comb
    begin
        push_data.cmd           = cmd;
        push_data.tree_id       = tree_id;
        push_data.node_addr     = node_addr;
        push_data.node.leaf     = node_is_leaf;
        push_data.node.feature  = node_feature;
        push_data.node.cutoff   = node_cutoff;
        push_data.node.left     = node_left;
        push_data.node.right    = node_right;
        push_data.node.label    = node_label;
        push_data.feature_index = feature_index;
        push_data.feature_value = feature_value;
    end

endmodule

/* hdl/dfi_back.sv */
module dfi_back #(
    parameter int TREES          = 8,
    parameter int NODES_PER_TREE = 256,
    parameter int FEATURES       = 32,
    parameter int CLASSES        = 16,
    parameter int WALK_LIMIT     = 21
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [3:0]       trees_in_use,
    input  logic             q_valid,
    input  dfi_pkg::dfi_op_t q_head,
    output logic             q_pop,
    output logic             done,
    output logic [3:0]       predicted_label,
    output logic [3:0]       winning_votes,
    output logic             walk_error
);

    import dfi_pkg::*;

    localparam int TREES_EFF  = (TREES > MAX_TREES) ? MAX_TREES : TREES;
    localparam int NODES_EFF  = (NODES_PER_TREE > MAX_NODES) ? MAX_NODES : NODES_PER_TREE;
    localparam int FEAT_EFF   = (FEATURES > MAX_FEATURES) ? MAX_FEATURES : FEATURES;
    localparam int CLS_EFF    = (CLASSES > MAX_CLASSES) ? MAX_CLASSES : CLASSES;
    localparam int TREE_W     = (TREES_EFF > 1) ? $clog2(TREES_EFF) : 1;
    localparam int TCNT_W     = $clog2(TREES_EFF + 1);
    localparam int SLOT_W     = $clog2(NODES_EFF);
    localparam int FEAT_W     = (FEAT_EFF > 1) ? $clog2(FEAT_EFF) : 1;
    localparam int CLS_W      = $clog2(CLS_EFF);
    localparam int VIS_W      = $clog2(WALK_LIMIT + 1);
    localparam int NODE_AW    = TREE_W + SLOT_W;
    localparam int NODE_DEPTH = 2 ** NODE_AW;
    localparam int NODE_W     = $bits(node_t);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_NREQ  = 3'd1;
    localparam logic [2:0] S_NDATA = 3'd2;
    localparam logic [2:0] S_FDATA = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [TCNT_W-1:0]  tree_reg, tree_next;
    logic [TCNT_W-1:0]  ntrees_reg, ntrees_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [VIS_W-1:0]   visited_reg, visited_next;
    logic               err_reg, err_next;
    logic [CLS_W-1:0]   scan_reg, scan_next;
    logic               done_reg, done_next;

    logic signed [31:0] cut_reg, cut_next;
    logic [7:0]         left_reg, left_next;
    logic [7:0]         right_reg, right_next;
    logic               feat_ok_reg, feat_ok_next;
    logic [3:0]         votes_reg [CLS_EFF];
    logic [3:0]         votes_next [CLS_EFF];
    logic [3:0]         best_reg, best_next;
    logic [3:0]         bestv_reg, bestv_next;
    logic [3:0]         label_reg, label_next;
    logic [3:0]         wvotes_reg, wvotes_next;
    logic               werr_reg, werr_next;

    logic               node_we;
    logic [NODE_AW-1:0] node_waddr;
    logic [NODE_AW-1:0] node_raddr;
    logic [NODE_W-1:0]  node_rdata;
    node_t              node_rd;
    logic               feat_we;
    logic [FEAT_W-1:0]  feat_raddr;
    logic [31:0]        feat_rdata;

    logic [SLOT_W-1:0]  wrap_lut [MAX_NODES];
    logic [TCNT_W-1:0]  ntrees_calc;
    logic [CLS_W-1:0]   vote_idx;
    logic [3:0]         vote_cur;
    logic               label_ok;
    logic               stop_walk;
    logic signed [31:0] x_val;
    logic [7:0]         child;
    logic [TCNT_W-1:0]  tree_inc;

    // Child slots wrap modulo the tree size
    for (genvar g = 0; g < MAX_NODES; g++)
    begin : g_wrap
        assign wrap_lut[g] = SLOT_W'(g % NODES_PER_TREE);
    end

    dfi_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (q_head.node),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    dfi_ram #(
        .WIDTH (32),
        .DEPTH (FEAT_EFF)
    ) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (q_head.feature_index[FEAT_W-1:0]),
        .wdata (q_head.feature_value),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    assign node_rd    = node_t'(node_rdata);
    assign node_waddr = {q_head.tree_id[TREE_W-1:0], q_head.node_addr[SLOT_W-1:0]};
    assign node_raddr = {tree_reg[TREE_W-1:0], slot_reg};
    assign feat_raddr = node_rd.feature[FEAT_W-1:0];

    always_comb
    begin
        if (trees_in_use == 4'd0)
        begin
            ntrees_calc = TCNT_W'(1);
        end
        else if (32'(trees_in_use) > TREES_EFF)
        begin
            ntrees_calc = TCNT_W'(TREES_EFF);
        end
        else
        begin
            ntrees_calc = TCNT_W'(trees_in_use);
        end
    end

    assign vote_idx  = (state_reg == S_SCAN) ? scan_reg : node_rd.label[CLS_W-1:0];
    assign vote_cur  = votes_reg[vote_idx];
    assign label_ok  = (32'(node_rd.label) < CLASSES);
    assign stop_walk = node_rd.leaf || (visited_reg >= VIS_W'(WALK_LIMIT));
    assign x_val     = feat_ok_reg ? $signed(feat_rdata) : 32'sd0;
    assign child     = (x_val <= cut_reg) ? left_reg : right_reg;
    assign tree_inc  = tree_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        tree_next    = tree_reg;
        ntrees_next  = ntrees_reg;
        slot_next    = slot_reg;
        visited_next = visited_reg;
        err_next     = err_reg;
        scan_next    = scan_reg;
        done_next    = 1'b0;
        cut_next     = cut_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        feat_ok_next = feat_ok_reg;
        votes_next   = votes_reg;
        best_next    = best_reg;
        bestv_next   = bestv_reg;
        label_next   = label_reg;
        wvotes_next  = wvotes_reg;
        werr_next    = werr_reg;
        q_pop        = 1'b0;
        node_we      = 1'b0;
        feat_we      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.cmd)
                        CMD_NODE: node_we = 1'b1;
                        CMD_FEAT: feat_we = 1'b1;
                        CMD_CLASSIFY:
                        begin
                            for (int c = 0; c < CLS_EFF; c++)
                            begin
                                votes_next[c] = 4'd0;
                            end
                            tree_next    = '0;
                            ntrees_next  = ntrees_calc;
                            slot_next    = '0;
                            visited_next = VIS_W'(1);
                            err_next     = 1'b0;
                            state_next   = S_NREQ;
                        end
                        default: ;
                    endcase
                end
            end
            S_NREQ:
            begin
                state_next = S_NDATA;
            end
            S_NDATA:
            begin
                if (stop_walk)
                begin
                    if (!node_rd.leaf)
                    begin
                        err_next = 1'b1;
                    end
                    if (label_ok)
                    begin
                        votes_next[vote_idx] = vote_cur + 4'd1;
                    end
                    if (tree_inc == ntrees_reg)
                    begin
                        scan_next  = '0;
                        best_next  = 4'd0;
                        bestv_next = 4'd0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        tree_next    = tree_inc;
                        slot_next    = '0;
                        visited_next = VIS_W'(1);
                        state_next   = S_NREQ;
                    end
                end
                else
                begin
                    // Hold the branch while the feature read completes
                    cut_next     = node_rd.cutoff;
                    left_next    = node_rd.left;
                    right_next   = node_rd.right;
                    feat_ok_next = (32'(node_rd.feature) < FEATURES);
                    state_next   = S_FDATA;
                end
            end
            S_FDATA:
            begin
                slot_next    = wrap_lut[child];
                visited_next = visited_reg + 1'b1;
                state_next   = S_NREQ;
            end
            S_SCAN:
            begin
                // Strict compare keeps the smallest label on a tie
                if (vote_cur > bestv_reg)
                begin
                    best_next  = 4'(scan_reg);
                    bestv_next = vote_cur;
                end
                if (scan_reg == CLS_W'(CLS_EFF - 1))
                begin
                    label_next  = best_next;
                    wvotes_next = bestv_next;
                    werr_next   = err_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tree_reg    <= '0;
            ntrees_reg  <= TCNT_W'(1);
            slot_reg    <= '0;
            visited_reg <= '0;
            err_reg     <= 1'b0;
            scan_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            tree_reg    <= tree_next;
            ntrees_reg  <= ntrees_next;
            slot_reg    <= slot_next;
            visited_reg <= visited_next;
            err_reg     <= err_next;
            scan_reg    <= scan_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cut_reg     <= cut_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        feat_ok_reg <= feat_ok_next;
        votes_reg   <= votes_next;
        best_reg    <= best_next;
        bestv_reg   <= bestv_next;
        label_reg   <= label_next;
        wvotes_reg  <= wvotes_next;
        werr_reg    <= werr_next;
    end

    assign done            = done_reg;
    assign predicted_label = label_reg;
    assign winning_votes   = wvotes_reg;
    assign walk_error      = werr_reg;

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == S_SCAN)
        else $error("result without a vote scan");
    a_votes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> 32'(wvotes_reg) <= TREES_EFF)
        else $error("winning votes exceed tree count");
    a_fdata_follows_node: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FDATA |-> $past(state_reg) == S_NDATA)
        else $error("feature compare without node read");

endmodule
